// ===== rtl/core/gmas_pkg.sv =====
// Shared types and constants of the gyro motion axis selector.
// Used by every module under rtl/core but gmas_fifo; depends on nothing else.
package gmas_pkg;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 15;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_MOTION_THRESHOLD = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SIGN_LOCK_LEVEL  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PEAK_LEVEL   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DOMINANCE_RATIO  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SIGN_SUM_MINIMUM = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_AXIS_USED_MASK   = 3'd5;

  // Selection status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PEAK_LOW  = 3'd1;
  localparam logic [2:0] ST_AMBIGUOUS = 3'd2;
  localparam logic [2:0] ST_CLAIMED   = 3'd3;
  localparam logic [2:0] ST_SIGN_WEAK = 3'd4;

  // Direction lock codes.
  localparam logic [1:0] LOCK_NONE = 2'd0;
  localparam logic [1:0] LOCK_POS  = 2'd1;
  localparam logic [1:0] LOCK_NEG  = 2'd2;

  // Queue depths; the result queue covers the back-end pipeline in flight.
  localparam int MQ_DEPTH = 4;
  localparam int OQ_DEPTH = 8;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH) + 1;

  typedef struct packed {
    logic [14:0] motion_threshold;
    logic [14:0] sign_lock_level;
    logic [14:0] min_peak_level;
    logic [9:0]  dominance_ratio;
    logic [14:0] sign_sum_minimum;
    logic [2:0]  axis_used_mask;
  } cfg_t;

  // One classified sample as it waits between front and back end.
  typedef struct packed {
    logic             clear_first;
    logic             accumulate;
    logic             motion_active;
    logic [2:0]       lock_hit;
    logic [2:0][15:0] rate;
    logic [2:0][15:0] mag;
  } item_t;

  typedef struct packed {
    logic       motion_active;
    logic [2:0] status;
    logic [1:0] axis;
    logic       negative;
  } result_t;

endpackage

// ===== rtl/core/gmas_fifo.sv =====
// Small first-in first-out queue of flip-flops with count, full and empty.
// Used between the front and back end and for the result words; no package.
module gmas_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage holds payload only, so it needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign count = count_r;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/core/gmas_front.sv =====
// Front end: takes the magnitude of each axis and classifies the sample.
// Depends on gmas_pkg for the configuration and queue word types.
module gmas_front (
  input  gmas_pkg::cfg_t         cfg,
  input  logic                   clear_first,
  input  logic                   accumulate,
  input  logic signed [15:0]     rate_x,
  input  logic signed [15:0]     rate_y,
  input  logic signed [15:0]     rate_z,
  output gmas_pkg::item_t        item
);

  import gmas_pkg::*;

  logic [2:0][15:0] rate;
  logic [2:0][15:0] mag;
  logic [2:0]       over_thr;
  logic [2:0]       lock_hit;

  assign rate[0] = rate_x;
  assign rate[1] = rate_y;
  assign rate[2] = rate_z;

  // Magnitude per axis; the most negative rate maps to 32768 without loss.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]      = rate[i][15] ? (~rate[i] + 16'd1) : rate[i];
      over_thr[i] = mag[i] > {1'b0, cfg.motion_threshold};
      lock_hit[i] = mag[i] >= {1'b0, cfg.sign_lock_level};
    end
  end

  // Pack the classified word for the queue.
  always_comb begin
    item.clear_first   = clear_first;
    item.accumulate    = accumulate;
    item.motion_active = |over_thr;
    item.lock_hit      = lock_hit;
    item.rate          = rate;
    item.mag           = mag;
  end

endmodule

// ===== rtl/core/gmas_back.sv =====
// Back end: per-axis accumulators and the pipelined axis selection.
// Depends on gmas_pkg; issues a word only when the result queue has room.
module gmas_back #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gmas_pkg::cfg_t                    cfg,
  input  logic                              mq_empty,
  input  gmas_pkg::item_t                   mq_item,
  output logic                              mq_pop,
  input  logic [gmas_pkg::OQ_CNT_W-1:0]     oq_count,
  output logic                              oq_push,
  output gmas_pkg::result_t                 oq_res
);

  import gmas_pkg::*;

  localparam int W  = SUM_WIDTH;
  localparam int PW = SUM_WIDTH + 10;
  localparam logic [W-1:0] SGN_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SGN_MIN = {1'b1, {(W-1){1'b0}}};

  // Accumulator state.
  logic [15:0]  peak_r [3];
  logic [15:0]  peak_nxt [3];
  logic [W-1:0] abs_r [3];
  logic [W-1:0] abs_nxt [3];
  logic [W-1:0] sgn_r [3];
  logic [W-1:0] sgn_nxt [3];
  logic [1:0]   lock_r [3];
  logic [1:0]   lock_nxt [3];

  logic [15:0]  base_peak [3];
  logic [W-1:0] base_abs [3];
  logic [W-1:0] base_sgn [3];
  logic [1:0]   base_lock [3];
  logic [W:0]   abs_sum [3];
  logic [W:0]   sgn_sum [3];

  logic [OQ_CNT_W:0] pending;
  logic              issue;

  // Pipeline valids and stage registers.
  logic         v1_r, v2_r, v3_r;
  logic         s1_motion_r;

  logic         gt01, gt2b, gt2s;
  logic [W-1:0] b01, s01;
  logic [1:0]   ax01;
  logic [W-1:0] best_c, second_c;
  logic [1:0]   ax_c;

  logic         s2_motion_r;
  logic [1:0]   s2_axis_r;
  logic [W-1:0] s2_best_r, s2_second_r;
  logic [15:0]  s2_peak_r;
  logic [1:0]   s2_lock_r;
  logic [W-1:0] s2_sgn_r;

  logic [W-1:0] sgn_mag;
  logic [PW-1:0] prod_c;

  logic          s3_motion_r;
  logic [1:0]    s3_axis_r;
  logic [PW-1:0] s3_scaled_r, s3_prod_r;
  logic          s3_second_nz_r, s3_peak_low_r, s3_claimed_r;
  logic [1:0]    s3_lock_r;
  logic          s3_sgn_neg_r, s3_sgn_weak_r;

  logic          ambiguous;

  // Issue only if every word in flight is sure of a place in the result queue.
  assign pending = {1'b0, oq_count} + (OQ_CNT_W+1)'(v1_r) + (OQ_CNT_W+1)'(v2_r)
                   + (OQ_CNT_W+1)'(v3_r);
  assign issue   = !mq_empty && (pending < (OQ_CNT_W+1)'(OQ_DEPTH));
  assign mq_pop  = issue;

  // Stage 1: optional clear, then saturating accumulation and direction lock.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      base_peak[i] = mq_item.clear_first ? '0 : peak_r[i];
      base_abs[i]  = mq_item.clear_first ? '0 : abs_r[i];
      base_sgn[i]  = mq_item.clear_first ? '0 : sgn_r[i];
      base_lock[i] = mq_item.clear_first ? LOCK_NONE : lock_r[i];
      abs_sum[i]   = {1'b0, base_abs[i]} + {{(W-15){1'b0}}, mq_item.mag[i]};
      sgn_sum[i]   = {base_sgn[i][W-1], base_sgn[i]}
                     + {{(W-15){mq_item.rate[i][15]}}, mq_item.rate[i]};
      peak_nxt[i]  = base_peak[i];
      abs_nxt[i]   = base_abs[i];
      sgn_nxt[i]   = base_sgn[i];
      lock_nxt[i]  = base_lock[i];
      if (mq_item.accumulate) begin
        if (mq_item.mag[i] > base_peak[i]) begin
          peak_nxt[i] = mq_item.mag[i];
        end
        abs_nxt[i] = abs_sum[i][W] ? '1 : abs_sum[i][W-1:0];
        if (sgn_sum[i][W] != sgn_sum[i][W-1]) begin
          sgn_nxt[i] = sgn_sum[i][W] ? SGN_MIN : SGN_MAX;
        end else begin
          sgn_nxt[i] = sgn_sum[i][W-1:0];
        end
        if (base_lock[i] == LOCK_NONE && mq_item.lock_hit[i]) begin
          lock_nxt[i] = mq_item.rate[i][15] ? LOCK_NEG : LOCK_POS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        peak_r[i] <= '0;
        abs_r[i]  <= '0;
        sgn_r[i]  <= '0;
        lock_r[i] <= LOCK_NONE;
      end
    end else if (issue) begin
      for (int i = 0; i < 3; i++) begin
        peak_r[i] <= peak_nxt[i];
        abs_r[i]  <= abs_nxt[i];
        sgn_r[i]  <= sgn_nxt[i];
        lock_r[i] <= lock_nxt[i];
      end
    end
  end

  // Stage 2: rank the absolute sums; the earliest axis wins a tie.
  always_comb begin
    gt01 = abs_r[1] > abs_r[0];
    b01  = gt01 ? abs_r[1] : abs_r[0];
    s01  = gt01 ? abs_r[0] : abs_r[1];
    ax01 = gt01 ? 2'd1 : 2'd0;
    gt2b = abs_r[2] > b01;
    gt2s = abs_r[2] > s01;
    if (gt2b) begin
      best_c   = abs_r[2];
      second_c = b01;
      ax_c     = 2'd2;
    end else begin
      best_c   = b01;
      second_c = gt2s ? abs_r[2] : s01;
      ax_c     = ax01;
    end
  end

  always_ff @(posedge clk) begin
    s1_motion_r <= mq_item.motion_active;
    s2_motion_r <= s1_motion_r;
    s2_axis_r   <= ax_c;
    s2_best_r   <= best_c;
    s2_second_r <= second_c;
    s2_peak_r   <= (ax_c == 2'd2) ? peak_r[2] : (ax_c == 2'd1) ? peak_r[1] : peak_r[0];
    s2_lock_r   <= (ax_c == 2'd2) ? lock_r[2] : (ax_c == 2'd1) ? lock_r[1] : lock_r[0];
    s2_sgn_r    <= (ax_c == 2'd2) ? sgn_r[2] : (ax_c == 2'd1) ? sgn_r[1] : sgn_r[0];
  end

  // Stage 3: runner-up times ratio, plus the independent checks.
  assign prod_c  = {10'd0, s2_second_r} * {{W{1'b0}}, cfg.dominance_ratio};
  assign sgn_mag = s2_sgn_r[W-1] ? (~s2_sgn_r + W'(1)) : s2_sgn_r;

  always_ff @(posedge clk) begin
    s3_motion_r    <= s2_motion_r;
    s3_axis_r      <= s2_axis_r;
    s3_scaled_r    <= {2'b00, s2_best_r, 8'd0};
    s3_prod_r      <= prod_c;
    s3_second_nz_r <= (s2_second_r != '0);
    s3_peak_low_r  <= s2_peak_r < {1'b0, cfg.min_peak_level};
    s3_claimed_r   <= (s2_axis_r == 2'd2) ? cfg.axis_used_mask[2] :
                      (s2_axis_r == 2'd1) ? cfg.axis_used_mask[1] : cfg.axis_used_mask[0];
    s3_lock_r      <= s2_lock_r;
    s3_sgn_neg_r   <= s2_sgn_r[W-1];
    s3_sgn_weak_r  <= sgn_mag < {{(W-15){1'b0}}, cfg.sign_sum_minimum};
  end

  // Stage 4: status priority and the result word.
  assign ambiguous = s3_second_nz_r && (s3_scaled_r < s3_prod_r);

  always_comb begin
    oq_res.motion_active = s3_motion_r;
    oq_res.status        = ST_OK;
    oq_res.axis          = 2'd0;
    oq_res.negative      = 1'b0;
    if (s3_peak_low_r) begin
      oq_res.status = ST_PEAK_LOW;
    end else if (ambiguous) begin
      oq_res.status = ST_AMBIGUOUS;
    end else if (s3_claimed_r) begin
      oq_res.status = ST_CLAIMED;
    end else if (s3_lock_r != LOCK_NONE) begin
      oq_res.axis     = s3_axis_r;
      oq_res.negative = (s3_lock_r == LOCK_NEG);
    end else if (s3_sgn_weak_r) begin
      oq_res.status = ST_SIGN_WEAK;
    end else begin
      oq_res.axis     = s3_axis_r;
      oq_res.negative = s3_sgn_neg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign oq_push = v3_r;

`ifndef SYNTHESIS
  a_room_on_push: assert property (@(posedge clk) disable iff (!rst_n)
      v3_r |-> (oq_count < OQ_CNT_W'(OQ_DEPTH)))
    else $error("result word arrives with the result queue full");
  a_winner_range: assert property (@(posedge clk) disable iff (!rst_n)
      v2_r |-> (s2_axis_r != 2'd3))
    else $error("winning axis out of range");
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
      !issue |=> ($stable(abs_r[0]) && $stable(sgn_r[1]) && $stable(lock_r[2])))
    else $error("accumulator changed without an issued word");
  a_issue_flows: assert property (@(posedge clk) disable iff (!rst_n)
      issue |=> ##2 v3_r)
    else $error("issued word lost in the selection pipeline");
`endif

endmodule

// ===== rtl/core/gyro_motion_axis_selector_core.sv =====
// Top level of the gyro motion axis selector: configuration registers and queues.
// Depends on gmas_pkg, gmas_front, gmas_fifo and gmas_back.
//
// Usage:
//   Input channel: drive in_clear_first, in_accumulate and in_rate_x/y/z with
//   in_push; a word is taken at a clock edge where in_push is high and in_full
//   is low. Rates are signed, 1/16 dps per LSB.
//   Result channel: while out_empty is low the oldest result word sits on the
//   out_ ports; it is taken at an edge where out_pop is high.
//   Configuration: cfg_we with cfg_index and cfg_wdata writes one register at
//   that edge; indexes above five are ignored. Write only while idle.
// Timing:
//   One word per cycle is sustained while the receiver keeps taking results. A word
//   passes the accumulator update, the sum ranking stage and the ratio multiply
//   stage in the back end on its way to the result ports.
//   If the receiver stalls, the 8-entry result queue and the 4-entry input
//   queue fill, and in_full rises; nothing is dropped.
// Reset (rst_n low, synchronous): queues empty, accumulators and direction
//   locks zero, registers return to their default values.
module gyro_motion_axis_selector_core #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_clear_first,
  input  logic                              in_accumulate,
  input  logic signed [15:0]                in_rate_x,
  input  logic signed [15:0]                in_rate_y,
  input  logic signed [15:0]                in_rate_z,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_motion_active,
  output logic [2:0]                        out_select_status,
  output logic [1:0]                        out_selected_axis,
  output logic                              out_selected_negative,
  input  logic                              cfg_we,
  input  logic [gmas_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [gmas_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import gmas_pkg::*;

  localparam int MQ_CNT_W = $clog2(MQ_DEPTH) + 1;

  cfg_t    cfg_r;
  item_t   front_item, mq_item;
  result_t oq_res_in, oq_res_out;

  logic                mq_push, mq_pop, mq_full, mq_empty;
  logic [MQ_CNT_W-1:0] mq_count;
  logic                oq_push, oq_pop, oq_full;
  logic [OQ_CNT_W-1:0] oq_count;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_threshold <= 15'd192;
      cfg_r.sign_lock_level  <= 15'd400;
      cfg_r.min_peak_level   <= 15'd320;
      cfg_r.dominance_ratio  <= 10'd307;
      cfg_r.sign_sum_minimum <= 15'd400;
      cfg_r.axis_used_mask   <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOTION_THRESHOLD: cfg_r.motion_threshold <= cfg_wdata;
        REG_SIGN_LOCK_LEVEL:  cfg_r.sign_lock_level  <= cfg_wdata;
        REG_MIN_PEAK_LEVEL:   cfg_r.min_peak_level   <= cfg_wdata;
        REG_DOMINANCE_RATIO:  cfg_r.dominance_ratio  <= cfg_wdata[9:0];
        REG_SIGN_SUM_MINIMUM: cfg_r.sign_sum_minimum <= cfg_wdata;
        REG_AXIS_USED_MASK:   cfg_r.axis_used_mask   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Front end classifies the incoming word.
  gmas_front u_front (
    .cfg         (cfg_r),
    .clear_first (in_clear_first),
    .accumulate  (in_accumulate),
    .rate_x      (in_rate_x),
    .rate_y      (in_rate_y),
    .rate_z      (in_rate_z),
    .item        (front_item)
  );

  // Queue between front and back end.
  assign mq_push = in_push && !mq_full;
  assign in_full = mq_full;

  gmas_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (MQ_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (front_item),
    .pop   (mq_pop),
    .rdata (mq_item),
    .full  (mq_full),
    .empty (mq_empty),
    .count (mq_count)
  );

  // Back end: accumulators and selection.
  gmas_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .mq_empty (mq_empty),
    .mq_item  (mq_item),
    .mq_pop   (mq_pop),
    .oq_count (oq_count),
    .oq_push  (oq_push),
    .oq_res   (oq_res_in)
  );

  // Result queue toward the receiver.
  assign oq_pop = out_pop && !out_empty;

  gmas_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OQ_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_res_in),
    .pop   (oq_pop),
    .rdata (oq_res_out),
    .full  (oq_full),
    .empty (out_empty),
    .count (oq_count)
  );

  assign out_motion_active     = oq_res_out.motion_active;
  assign out_select_status     = oq_res_out.status;
  assign out_selected_axis     = oq_res_out.axis;
  assign out_selected_negative = oq_res_out.negative;

`ifndef SYNTHESIS
  a_out_never_full: assert property (@(posedge clk) disable iff (!rst_n)
      oq_full |-> !oq_push)
    else $error("result queue full while a result word arrives");
  a_mid_count_full: assert property (@(posedge clk) disable iff (!rst_n)
      mq_full |-> (mq_count == MQ_CNT_W'(MQ_DEPTH)))
    else $error("input queue full flag disagrees with its count");
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
      mq_push |=> !mq_empty)
    else $error("accepted word missing from the input queue");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of gyro_motion_axis_selector_core: accumulation and axis choice.
// It uses gmas_pkg for register indexes, codes and the result struct, and needs only the RTL.

// Scoreboard: it mirrors the accumulators and registers, predicts one result word per accepted
// sample word and compares each popped result word with the oldest prediction.
class axis_selection_board #(int SUM_W = 32);
  localparam longint ABS_TOP = (longint'(1) << SUM_W) - 1;
  localparam longint SGN_TOP = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SGN_BOT = -SGN_TOP - 1;

  gmas_pkg::cfg_t regs;
  longint peak_mag[3];
  longint abs_total[3];
  longint sgn_total[3];
  logic [1:0] lock_dir[3];
  gmas_pkg::result_t expected_selections[$];
  int words_in;
  int words_out;
  int errors;
  int status_count[5];

  function new();
    regs.motion_threshold = 15'd192;
    regs.sign_lock_level  = 15'd400;
    regs.min_peak_level   = 15'd320;
    regs.dominance_ratio  = 10'd307;
    regs.sign_sum_minimum = 15'd400;
    regs.axis_used_mask   = 3'd0;
    clear_accumulators();
  endfunction

  function void clear_accumulators();
    for (int i = 0; i < 3; i++) begin
      peak_mag[i] = 0;
      abs_total[i] = 0;
      sgn_total[i] = 0;
      lock_dir[i] = gmas_pkg::LOCK_NONE;
    end
  endfunction

  // Register writes keep only the bits that each register holds; unknown indexes do nothing.
  function void write_reg(logic [gmas_pkg::CFG_ADDR_W-1:0] idx,
                          logic [gmas_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      gmas_pkg::REG_MOTION_THRESHOLD: regs.motion_threshold = data;
      gmas_pkg::REG_SIGN_LOCK_LEVEL:  regs.sign_lock_level  = data;
      gmas_pkg::REG_MIN_PEAK_LEVEL:   regs.min_peak_level   = data;
      gmas_pkg::REG_DOMINANCE_RATIO:  regs.dominance_ratio  = data[9:0];
      gmas_pkg::REG_SIGN_SUM_MINIMUM: regs.sign_sum_minimum = data;
      gmas_pkg::REG_AXIS_USED_MASK:   regs.axis_used_mask   = data[2:0];
      default: ;
    endcase
  endfunction

  // Works out the selection that one accepted sample word must produce.
  function void predict_selection(logic clr, logic acc, logic signed [15:0] rx,
                                  logic signed [15:0] ry, logic signed [15:0] rz);
    longint rate[3];
    longint mag[3];
    longint total;
    longint best;
    longint second;
    longint m;
    int win;
    logic active;
    logic [2:0] st;
    logic negv;
    gmas_pkg::result_t r;
    rate[0] = rx;
    rate[1] = ry;
    rate[2] = rz;
    if (clr) clear_accumulators();
    active = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = rate[i] < 0 ? -rate[i] : rate[i];
      if (mag[i] > longint'(regs.motion_threshold)) active = 1'b1;
    end
    // Accumulate with saturation; the first large enough sample locks the direction.
    if (acc) begin
      for (int i = 0; i < 3; i++) begin
        if (mag[i] > peak_mag[i]) peak_mag[i] = mag[i];
        total = abs_total[i] + mag[i];
        abs_total[i] = total > ABS_TOP ? ABS_TOP : total;
        total = sgn_total[i] + rate[i];
        sgn_total[i] = total > SGN_TOP ? SGN_TOP : (total < SGN_BOT ? SGN_BOT : total);
        if (lock_dir[i] == gmas_pkg::LOCK_NONE && mag[i] >= longint'(regs.sign_lock_level))
          lock_dir[i] = rate[i] >= 0 ? gmas_pkg::LOCK_POS : gmas_pkg::LOCK_NEG;
      end
    end
    // Rank the absolute sums; on a tie the lower axis keeps the lead.
    best = -1;
    second = -1;
    win = 0;
    for (int i = 0; i < 3; i++) begin
      if (abs_total[i] > best) begin
        second = best;
        best = abs_total[i];
        win = i;
      end else if (abs_total[i] > second) begin
        second = abs_total[i];
      end
    end
    st = gmas_pkg::ST_OK;
    negv = 1'b0;
    if (peak_mag[win] < longint'(regs.min_peak_level)) begin
      st = gmas_pkg::ST_PEAK_LOW;
    end else if (second > 0 && best * 256 < second * longint'(regs.dominance_ratio)) begin
      st = gmas_pkg::ST_AMBIGUOUS;
    end else if (regs.axis_used_mask[win]) begin
      st = gmas_pkg::ST_CLAIMED;
    end else if (lock_dir[win] != gmas_pkg::LOCK_NONE) begin
      negv = lock_dir[win] == gmas_pkg::LOCK_NEG;
    end else begin
      m = sgn_total[win] < 0 ? -sgn_total[win] : sgn_total[win];
      if (m < longint'(regs.sign_sum_minimum)) st = gmas_pkg::ST_SIGN_WEAK;
      else negv = sgn_total[win] < 0;
    end
    r.motion_active = active;
    r.status = st;
    r.axis = st == gmas_pkg::ST_OK ? 2'(win) : 2'd0;
    r.negative = st == gmas_pkg::ST_OK ? negv : 1'b0;
    expected_selections.push_back(r);
    status_count[st]++;
    words_in++;
  endfunction

  function void report_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function void compare_selection(gmas_pkg::result_t got);
    gmas_pkg::result_t want;
    words_out++;
    if (expected_selections.size() == 0) begin
      errors++;
      $display("%0t: result word with nothing expected, got status %0d axis %0d",
               $time, got.status, got.axis);
    end else begin
      want = expected_selections.pop_front();
      report_field("motion_active", want.motion_active, got.motion_active);
      report_field("select_status", want.status, got.status);
      report_field("selected_axis", want.axis, got.axis);
      report_field("selected_negative", want.negative, got.negative);
    end
  endfunction

  function int outstanding();
    return expected_selections.size();
  endfunction
endclass

module tb;
  import gmas_pkg::*;

  localparam int SUM_W = 32;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int FULL_SCALE_WORDS = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_clear_first = 1'b0;
  logic in_accumulate = 1'b0;
  logic signed [15:0] in_rate_x = '0;
  logic signed [15:0] in_rate_y = '0;
  logic signed [15:0] in_rate_z = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_motion_active;
  logic [2:0] out_select_status;
  logic [1:0] out_selected_axis;
  logic out_selected_negative;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  axis_selection_board #(SUM_W) sb;
  longint cycles = 0;
  int push_mode = 1;
  int pop_mode = 1;
  int settings_applied = 0;

  gyro_motion_axis_selector_core #(.SUM_WIDTH(SUM_W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_clear_first(in_clear_first),
    .in_accumulate(in_accumulate),
    .in_rate_x(in_rate_x),
    .in_rate_y(in_rate_y),
    .in_rate_z(in_rate_z),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_motion_active(out_motion_active),
    .out_select_status(out_select_status),
    .out_selected_axis(out_selected_axis),
    .out_selected_negative(out_selected_negative),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               sb.outstanding());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Both monitors sample the values that stood before the edge.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full)
      sb.predict_selection(in_clear_first, in_accumulate, in_rate_x, in_rate_y, in_rate_z);
  end

  always @(posedge clk) begin
    gmas_pkg::result_t got;
    got.motion_active = out_motion_active;
    got.status = out_select_status;
    got.axis = out_selected_axis;
    got.negative = out_selected_negative;
    if (rst_n && out_pop && !out_empty) sb.compare_selection(got);
  end

  // Mode 0 never idles, mode 1 idles at random on every word, mode 2 idles now and then.
  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 14);
      default: return $urandom_range(0, 7) == 0 ? $urandom_range(1, 14) : 0;
    endcase
  endfunction

  // Result side: pops one word at a time with random stalls in front of each.
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_gap(pop_mode);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
    end
  end

  // Offers one sample word and returns at the edge that takes it; push stays high.
  task automatic push_word(input logic clr, input logic acc, input int x, input int y,
                           input int z);
    int gap;
    gap = draw_gap(push_mode);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_clear_first <= clr;
    in_accumulate <= acc;
    in_rate_x <= 16'(x);
    in_rate_y <= 16'(y);
    in_rate_z <= 16'(z);
    do @(posedge clk); while (in_full);
  endtask

  // Stops input and waits until every prediction is met and the pipeline is quiet.
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input int data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    @(posedge clk);
    sb.write_reg(idx, CFG_DATA_W'(data));
  endtask

  // Writes all six registers, after a write to an unused index that must be ignored.
  task automatic apply_setting(input int thr, input int lock_lvl, input int peak_lvl,
                               input int ratio, input int sum_min, input int mask);
    cfg_write(REG_AXIS_USED_MASK + 3'($urandom_range(1, 2)), $urandom_range(0, 32767));
    cfg_write(REG_MOTION_THRESHOLD, thr);
    cfg_write(REG_SIGN_LOCK_LEVEL, lock_lvl);
    cfg_write(REG_MIN_PEAK_LEVEL, peak_lvl);
    cfg_write(REG_DOMINANCE_RATIO, ratio);
    cfg_write(REG_SIGN_SUM_MINIMUM, sum_min);
    cfg_write(REG_AXIS_USED_MASK, mask);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Random part: mostly gesture-like runs (clear, then samples with one dominant axis of
  // mostly steady sign), with raw noise words and broken runs mixed in.
  task automatic run_random(input int n);
    int left;
    int len;
    int dom;
    int scale;
    int m;
    int v[3];
    logic dneg;
    logic clr;
    logic acc;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        push_word($urandom_range(0, 1), $urandom_range(0, 1), $urandom, $urandom, $urandom);
        left--;
      end else begin
        len = $urandom_range(1, 12);
        dom = $urandom_range(0, 2);
        dneg = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
          0: scale = 600;
          1: scale = 4000;
          2: scale = 32768;
          default: scale = 200;
        endcase
        for (int j = 0; j < len; j++) begin
          clr = j == 0 ? $urandom_range(0, 3) != 0 : $urandom_range(0, 30) == 0;
          acc = $urandom_range(0, 9) != 0;
          for (int a = 0; a < 3; a++) begin
            if (a == dom) begin
              m = $urandom_range(scale / 4, scale);
              v[a] = (dneg ^ ($urandom_range(0, 7) == 0)) ? -m : m;
            end else begin
              m = $urandom_range(0, scale / 2);
              v[a] = $urandom_range(0, 1) ? -m : m;
            end
            if (v[a] > 32767) v[a] = 32767;
          end
          push_word(clr, acc, v[0], v[1], v[2]);
        end
        left -= len;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words on the reset values of the registers.
    push_word(1, 0, 0, 0, 0);                 // Clear alone: peak too low.
    push_word(0, 1, -32768, 0, 0);            // Most negative rate, magnitude 32768, locks.
    push_word(0, 1, 32767, -1, 1);
    push_word(1, 1, 100, 100, 100);           // Three-way tie, peak low, no motion.
    push_word(0, 1, 193, 193, 193);           // Just above the motion threshold.
    push_word(0, 1, 500, 500, 500);           // Tie with big peaks: ambiguous.
    push_word(1, 1, 0, 1000, 0);              // Runner-up sum zero skips dominance.
    push_word(1, 1, 0, 0, -399);              // Unlocked, signed sum too small.
    push_word(0, 1, 0, 0, -1);                // Signed sum reaches the minimum.
    push_word(0, 0, 32767, -32768, 0);        // No accumulation: state unchanged.
    push_word(1, 0, -32768, 0, 0);
    push_word(1, 1, -32768, -32768, -32768);
    push_word(1, 1, 32767, -32768, 0);

    // All registers at their floor: zero lock level locks a zero rate, ratio zero.
    settle();
    apply_setting(0, 0, 0, 0, 0, 0);
    push_word(1, 1, 0, 0, 0);
    push_word(0, 1, -5, 0, 0);
    push_word(1, 1, -300, -299, 0);

    // No locking, zero sign minimum: a zero signed sum falls back to positive.
    settle();
    apply_setting(192, 32767, 0, 307, 0, 0);
    push_word(1, 1, 100, 0, 0);
    push_word(0, 1, -100, 0, 0);
    push_word(0, 1, -50, 0, 0);
    settle();
    cfg_write(REG_AXIS_USED_MASK, 1);
    cfg_we <= 1'b0;
    push_word(0, 1, -1000, 0, 0);             // Winner already claimed.
    push_word(1, 1, 0, -5000, 0);

    // Random phases, each under its own setting and its own idling on both sides.
    for (int p = 0; p < 8; p++) begin
      settle();
      push_mode = p == 3 ? 0 : $urandom_range(0, 2);
      pop_mode = p == 5 ? 0 : $urandom_range(0, 2);
      case (p)
        0: apply_setting(32767, 32767, 32767, 32767, 32767, 32767);
        1: apply_setting(0, 0, 0, 0, 0, 0);
        2: apply_setting(192, 400, 320, 307, 400, 0);
        3: apply_setting(100, 200, 300, 256, 300, 0);
        4: apply_setting(0, 0, 0, 1023, 0, 7);
        default: apply_setting($urandom_range(0, 1500), $urandom_range(0, 3000),
                               $urandom_range(0, 3000), $urandom_range(0, 1023),
                               $urandom_range(0, 5000),
                               $urandom_range(0, 1) ? $urandom_range(0, 7) : 0);
      endcase
      run_random(100);
    end

    // Short back-to-back run at the extremes of the rate range on every axis.
    settle();
    push_mode = 0;
    pop_mode = 0;
    apply_setting(192, 400, 320, 307, 400, 0);
    for (int k = 0; k < FULL_SCALE_WORDS; k++)
      push_word(k == 0, 1, -32768, 32767, $urandom_range(0, 1) ? 32767 : -32768);

    settle();
    $display("Checked %0d of %0d sample words under %0d register settings.",
             sb.words_out, sb.words_in, settings_applied);
    $display("Outcomes: %0d accepted, %0d peak low, %0d ambiguous, %0d claimed, %0d weak sign.",
             sb.status_count[ST_OK], sb.status_count[ST_PEAK_LOW],
             sb.status_count[ST_AMBIGUOUS], sb.status_count[ST_CLAIMED],
             sb.status_count[ST_SIGN_WEAK]);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/gmas_pkg.sv
rtl/core/gmas_fifo.sv
rtl/core/gmas_front.sv
rtl/core/gmas_back.sv
rtl/core/gyro_motion_axis_selector_core.sv
tb/tb.sv
